FILE: src/pld_pkg.sv
package pld_pkg;

  localparam int ADDR_W   = 18;
  localparam int COLOR_W  = 32;
  localparam int RGB_W    = 24;
  localparam int IDX_W    = 8;
  localparam int CHAN_W   = 8;
  localparam int OPCODE_W = 2;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SOF   = 2'd2;

  localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hFF;

  localparam int SRC_WIDTH_DEF       = 320;
  localparam int SRC_HEIGHT_DEF      = 200;
  localparam int DST_PITCH_DEF       = 640;
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    entry_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [IDX_W-1:0]    pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               frame_done;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [COLOR_W-1:0] color;
    logic               done;
  } pix_cmd_t;

endpackage

FILE: src/palette_lookup_pixel_doubler_unit.sv
// Pixel words pass the staging register, queue and back-end command register, and are
// taken while earlier ones are still written; the back end gives one write per cycle
// unless out_ready stalls; load and frame-start words go one per cycle if in_ready.
// Reset: synchronous, active low; it clears the position and all handshake state.
// Palette contents are undefined after reset until loaded.
module palette_lookup_pixel_doubler_unit #(
  parameter int SRC_WIDTH       = pld_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT      = pld_pkg::SRC_HEIGHT_DEF,
  parameter int DST_PITCH       = pld_pkg::DST_PITCH_DEF,
  parameter int PALETTE_ENTRIES = pld_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pld_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pld_pkg::out_word_t out_data
);

  logic              q_push_valid;
  logic              q_push_ready;
  pld_pkg::pix_cmd_t q_push_data;
  logic              q_pop_valid;
  logic              q_pop_ready;
  pld_pkg::pix_cmd_t q_pop_data;

  pld_front #(
    .SRC_WIDTH       (SRC_WIDTH),
    .SRC_HEIGHT      (SRC_HEIGHT),
    .DST_PITCH       (DST_PITCH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  pld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  pld_back #(
    .DST_PITCH (DST_PITCH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.last)
    else $error("frame_done raised on a write that is not the last of its pixel");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
    else $error("staged pixel command changed while the queue was full");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid directly after reset");

endmodule

FILE: src/pld_front.sv
module pld_front #(
  parameter int SRC_WIDTH       = pld_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT      = pld_pkg::SRC_HEIGHT_DEF,
  parameter int DST_PITCH       = pld_pkg::DST_PITCH_DEF,
  parameter int PALETTE_ENTRIES = pld_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pld_pkg::in_word_t  in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output pld_pkg::pix_cmd_t  push_data
);

  localparam int AW     = pld_pkg::ADDR_W;
  localparam int IW     = pld_pkg::IDX_W;
  localparam int RW     = pld_pkg::RGB_W;
  localparam int COL_W  = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int ROW_W  = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam logic [IW:0]      PAL_LIMIT = (IW + 1)'(PALETTE_ENTRIES);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SRC_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SRC_HEIGHT - 1);
  localparam logic [AW-1:0]    ROW_STEP  = AW'(2 * DST_PITCH);

  logic [RW-1:0] pal_mem [PALETTE_ENTRIES];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [AW-1:0]    row_base_r, row_base_nxt;

  logic             stg_v_r, stg_v_nxt;
  logic [AW-1:0]    stg_base_r;
  logic             stg_done_r;
  logic             stg_inr_r;
  logic [RW-1:0]    rd_r;

  logic accept;
  logic is_pixel;
  logic is_load;
  logic is_sof;
  logic wr_en;
  logic rd_en;
  logic pix_inr;
  logic col_last;
  logic row_last;

  assign in_ready = !stg_v_r || push_ready;
  assign accept   = in_valid && in_ready;
  assign is_pixel = in_data.opcode == pld_pkg::OP_PIXEL;
  assign is_load  = in_data.opcode == pld_pkg::OP_LOAD;
  assign is_sof   = in_data.opcode == pld_pkg::OP_SOF;
  assign wr_en    = accept && is_load && ({1'b0, in_data.entry_index} < PAL_LIMIT);
  assign pix_inr  = {1'b0, in_data.pixel_value} < PAL_LIMIT;
  assign rd_en    = accept && is_pixel && pix_inr;
  assign col_last = col_r == COL_LAST;
  assign row_last = row_r == ROW_LAST;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[in_data.entry_index[PAL_AW-1:0]] <= {in_data.red, in_data.green, in_data.blue};
    end
    if (rd_en) begin
      rd_r <= pal_mem[in_data.pixel_value[PAL_AW-1:0]];
    end
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    if (accept && is_pixel) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt      = '0;
          row_base_nxt = '0;
        end else begin
          row_nxt      = row_r + 1'b1;
          row_base_nxt = row_base_r + ROW_STEP;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end else if (accept && is_sof) begin
      col_nxt      = '0;
      row_nxt      = '0;
      row_base_nxt = '0;
    end
  end

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (accept && is_pixel) begin
      stg_v_nxt = 1'b1;
    end else if (push_ready) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
      stg_v_r    <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
      stg_v_r    <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      stg_base_r <= row_base_r + AW'({col_r, 1'b0});
      stg_done_r <= col_last && row_last;
      stg_inr_r  <= pix_inr;
    end
  end

  assign push_valid      = stg_v_r;
  assign push_data.base  = stg_base_r;
  assign push_data.color = {pld_pkg::OPAQUE_ALPHA, stg_inr_r ? rd_r : RW'(0)};
  assign push_data.done  = stg_done_r;

endmodule

FILE: src/pld_queue.sv
module pld_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  pld_pkg::pix_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pld_pkg::pix_cmd_t pop_data
);

  localparam int QD    = pld_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);

  pld_pkg::pix_cmd_t slots_r [QD];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != CNT_W'(QD);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/pld_back.sv
module pld_back #(
  parameter int DST_PITCH = pld_pkg::DST_PITCH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  pld_pkg::pix_cmd_t  pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pld_pkg::out_word_t out_data
);

  localparam int AW = pld_pkg::ADDR_W;

  localparam logic [AW-1:0] PITCH    = AW'(DST_PITCH);
  localparam logic [1:0]    PH_LAST  = 2'd3;

  pld_pkg::pix_cmd_t  cur_r;
  logic               cur_v_r, cur_v_nxt;
  logic [1:0]         phase_r, phase_nxt;
  pld_pkg::out_word_t out_r;
  logic               out_v_r, out_v_nxt;

  logic          out_free;
  logic          produce;
  logic          finish;
  logic [AW-1:0] addr;

  assign out_free  = !out_v_r || out_ready;
  assign produce   = cur_v_r && out_free;
  assign finish    = produce && (phase_r == PH_LAST);
  assign pop_ready = !cur_v_r || finish;
  assign addr      = cur_r.base + (phase_r[1] ? PITCH : AW'(0)) + AW'(phase_r[0]);

  always_comb begin
    cur_v_nxt = cur_v_r;
    phase_nxt = phase_r;
    out_v_nxt = out_v_r;
    if (pop_ready) begin
      cur_v_nxt = pop_valid;
    end
    if (produce) begin
      phase_nxt = phase_r + 1'b1;
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      phase_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      phase_r <= phase_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      cur_r <= pop_data;
    end
    if (produce) begin
      out_r.write_address <= addr;
      out_r.color         <= cur_r.color;
      out_r.last          <= phase_r == PH_LAST;
      out_r.frame_done    <= (phase_r == PH_LAST) && cur_r.done;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
